[src/cau_pkg.sv]
package cau_pkg;

  // default word format, Q16.16
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  localparam int FUNC_BITS = 3;

  // operation codes carried in the input tuser
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_MAG = 3'd4,
    FUNC_R2C = 3'd5
  } func_e;

endpackage

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit on signed fixed-point words (Q16.16 by default).
// Input channel s_axis: tuser carries the operation (add, subtract, multiply,
// divide, magnitude of A, real to complex), tdata the operands A and B.
// Output channel m_axis: tdata carries the result, tuser the flags
// div_by_zero and overflow. Every request gives exactly one result.
// A request passes, from accept to result, through these stages:
// three set-up stages (products, exact sums, sign/magnitude split), a chain
// of WORD_BITS cells that each settle one bit of both quotients or of the
// root, and one saturation stage that is also the output register.
// Throughput is one request per cycle until a stall on m_axis fills the pipe.
// Every stage has a valid bit and loads whenever its successor is free or
// moving, so a stall on m_axis only fills empty slots; s_axis_tready falls
// once the whole pipe is full. Reset empties the pipe; no state survives
// between requests, and results leave in request order.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int IW = ((4 * WORD_BITS + 7) / 8) * 8,
  localparam int OW = ((2 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IW-1:0]        s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  logic [FUNC_BITS-1:0] s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OW-1:0]        m_axis_tdata,  // res_re, res_im
  output logic [1:0]           m_axis_tuser   // div_by_zero, overflow
);

  localparam int W   = WORD_BITS;
  localparam int MW  = 2 * W + 1;
  localparam int NW  = 2 * W + FRAC_BITS + 1;
  localparam int NST = W + 4;

  // stage valids and ready chain
  logic [NST-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[NST-1] = ~v_q[NST-1] | m_axis_tready;
    for (int j = NST - 2; j >= 0; j--) begin
      rdy[j] = ~v_q[j] | rdy[j+1];
    end
  end

  always_comb begin
    for (int j = 0; j < NST; j++) begin
      if (rdy[j]) begin
        v_d[j] = (j == 0) ? s_axis_tvalid : v_q[(j == 0) ? 0 : j - 1];
      end else begin
        v_d[j] = v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NST-1];

  // chain signals, index 0 is the front end output
  logic [FUNC_BITS-1:0] func_c   [W+1];
  logic                 dz_c     [W+1];
  logic                 re_neg_c [W+1];
  logic                 im_neg_c [W+1];
  logic [MW-1:0]        re_mag_c [W+1];
  logic [MW-1:0]        im_mag_c [W+1];
  logic                 big_re_c [W+1];
  logic                 big_im_c [W+1];
  logic [2*W-1:0]       den_c    [W+1];
  logic [NW-1:0]        rem_re_c [W+1];
  logic [NW-1:0]        rem_im_c [W+1];

  cau_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (rdy[2:0]),
    .func_i   (s_axis_tuser),
    .a_re_i   ($signed(s_axis_tdata[W-1:0])),
    .a_im_i   ($signed(s_axis_tdata[2*W-1:W])),
    .b_re_i   ($signed(s_axis_tdata[3*W-1:2*W])),
    .b_im_i   ($signed(s_axis_tdata[4*W-1:3*W])),
    .func_o   (func_c[0]),
    .dz_o     (dz_c[0]),
    .re_neg_o (re_neg_c[0]),
    .im_neg_o (im_neg_c[0]),
    .re_mag_o (re_mag_c[0]),
    .im_mag_o (im_mag_c[0]),
    .big_re_o (big_re_c[0]),
    .big_im_o (big_im_c[0]),
    .den_o    (den_c[0]),
    .rem_re_o (rem_re_c[0]),
    .rem_im_o (rem_im_c[0])
  );

  // one cell per result bit, most significant first
  for (genvar i = 0; i < W; i++) begin : g_cell
    cau_cell #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (rdy[3+i]),
      .func_i   (func_c[i]),
      .dz_i     (dz_c[i]),
      .re_neg_i (re_neg_c[i]),
      .im_neg_i (im_neg_c[i]),
      .re_mag_i (re_mag_c[i]),
      .im_mag_i (im_mag_c[i]),
      .big_re_i (big_re_c[i]),
      .big_im_i (big_im_c[i]),
      .den_i    (den_c[i]),
      .rem_re_i (rem_re_c[i]),
      .rem_im_i (rem_im_c[i]),
      .func_o   (func_c[i+1]),
      .dz_o     (dz_c[i+1]),
      .re_neg_o (re_neg_c[i+1]),
      .im_neg_o (im_neg_c[i+1]),
      .re_mag_o (re_mag_c[i+1]),
      .im_mag_o (im_mag_c[i+1]),
      .big_re_o (big_re_c[i+1]),
      .big_im_o (big_im_c[i+1]),
      .den_o    (den_c[i+1]),
      .rem_re_o (rem_re_c[i+1]),
      .rem_im_o (rem_im_c[i+1])
    );
  end

  // saturation to the word range
  localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  logic          ovf_re, ovf_im;
  logic [W-1:0]  re_d, im_d;
  logic [W-1:0]  res_re_q, res_im_q;
  logic          dz_q, ovf_q;

  assign ovf_re = big_re_c[W] |
                  (re_neg_c[W] ? (re_mag_c[W] > HALF) : (re_mag_c[W] > HALF - MW'(1)));
  assign ovf_im = big_im_c[W] |
                  (im_neg_c[W] ? (im_mag_c[W] > HALF) : (im_mag_c[W] > HALF - MW'(1)));

  always_comb begin
    if (ovf_re) begin
      re_d = re_neg_c[W] ? WMIN : WMAX;
    end else begin
      re_d = re_neg_c[W] ? W'(-re_mag_c[W][W-1:0]) : re_mag_c[W][W-1:0];
    end
    if (ovf_im) begin
      im_d = im_neg_c[W] ? WMIN : WMAX;
    end else begin
      im_d = im_neg_c[W] ? W'(-im_mag_c[W][W-1:0]) : im_mag_c[W][W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      res_re_q <= dz_c[W] ? '0 : re_d;
      res_im_q <= dz_c[W] ? '0 : im_d;
      dz_q     <= dz_c[W];
      ovf_q    <= ~dz_c[W] & (ovf_re | ovf_im);
    end
  end

  assign m_axis_tdata = OW'({res_im_q, res_re_q});
  assign m_axis_tuser = {ovf_q, dz_q};

`ifndef ASSERT_OFF
  // a zero divisor gives a clean zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      res_re_q == '0 && res_im_q == '0 && !m_axis_tuser[1])
  else $error("zero divisor result not cleared");

  // overflow only with a saturated part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      res_re_q == WMAX || res_re_q == WMIN || res_im_q == WMAX || res_im_q == WMIN)
  else $error("overflow flagged without saturation");

  // an empty input slot always takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> s_axis_tready)
  else $error("input stalled with empty first stage");

  // a stalled result stays in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res_re_q))
  else $error("stalled result lost");
`endif

endmodule

[src/cau_front.sv]
module cau_front import cau_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic [FUNC_BITS-1:0]          func_i,
  input  logic signed [WORD_BITS-1:0]   a_re_i,
  input  logic signed [WORD_BITS-1:0]   a_im_i,
  input  logic signed [WORD_BITS-1:0]   b_re_i,
  input  logic signed [WORD_BITS-1:0]   b_im_i,
  output logic [FUNC_BITS-1:0]          func_o,
  output logic                          dz_o,
  output logic                          re_neg_o,
  output logic                          im_neg_o,
  output logic [2*WORD_BITS:0]          re_mag_o,
  output logic [2*WORD_BITS:0]          im_mag_o,
  output logic                          big_re_o,
  output logic                          big_im_o,
  output logic [2*WORD_BITS-1:0]        den_o,
  output logic [2*WORD_BITS+FRAC_BITS:0] rem_re_o,
  output logic [2*WORD_BITS+FRAC_BITS:0] rem_im_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NW = 2 * W + FRAC_BITS + 1;
  localparam int CW = NW + W;

  // stage 1: products
  logic [FUNC_BITS-1:0]  f1_q;
  logic signed [W-1:0]   ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0]  sq_ar_q, sq_ai_q, sq_br_q, sq_bi_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      f1_q    <= func_i;
      ar1_q   <= a_re_i;
      ai1_q   <= a_im_i;
      br1_q   <= b_re_i;
      bi1_q   <= b_im_i;
      p_rr_q  <= PW'(a_re_i) * PW'(b_re_i);
      p_ii_q  <= PW'(a_im_i) * PW'(b_im_i);
      p_ri_q  <= PW'(a_re_i) * PW'(b_im_i);
      p_ir_q  <= PW'(a_im_i) * PW'(b_re_i);
      sq_ar_q <= PW'(a_re_i) * PW'(a_re_i);
      sq_ai_q <= PW'(a_im_i) * PW'(a_im_i);
      sq_br_q <= PW'(b_re_i) * PW'(b_re_i);
      sq_bi_q <= PW'(b_im_i) * PW'(b_im_i);
    end
  end

  // stage 2: exact sums
  logic [FUNC_BITS-1:0]  f2_q;
  logic signed [SW-1:0]  sre_d, sim_d, sre2_q, sim2_q, nre2_q, nim2_q;
  logic [PW-1:0]         den2_q, mag2_q;

  always_comb begin
    sre_d = '0;
    sim_d = '0;
    unique case (func_e'(f1_q))
      FUNC_ADD: begin
        sre_d = SW'(ar1_q) + SW'(br1_q);
        sim_d = SW'(ai1_q) + SW'(bi1_q);
      end
      FUNC_SUB: begin
        sre_d = SW'(ar1_q) - SW'(br1_q);
        sim_d = SW'(ai1_q) - SW'(bi1_q);
      end
      FUNC_MUL: begin
        sre_d = SW'(p_rr_q) - SW'(p_ii_q);
        sim_d = SW'(p_ri_q) + SW'(p_ir_q);
      end
      FUNC_R2C: sre_d = SW'(ar1_q);
      default: begin
        sre_d = '0;
        sim_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      f2_q   <= f1_q;
      sre2_q <= sre_d;
      sim2_q <= sim_d;
      nre2_q <= SW'(p_rr_q) + SW'(p_ii_q);
      nim2_q <= SW'(p_ir_q) - SW'(p_ri_q);
      den2_q <= $unsigned(sq_br_q) + $unsigned(sq_bi_q);
      mag2_q <= $unsigned(sq_ar_q) + $unsigned(sq_ai_q);
    end
  end

  // stage 3: sign and magnitude, divider set-up
  logic [SW-1:0] sre_abs, sim_abs, nre_abs, nim_abs;
  logic [NW-1:0] nre_sh, nim_sh;
  logic [CW-1:0] den_top;

  assign sre_abs = sre2_q[SW-1] ? SW'(-sre2_q) : SW'(sre2_q);
  assign sim_abs = sim2_q[SW-1] ? SW'(-sim2_q) : SW'(sim2_q);
  assign nre_abs = nre2_q[SW-1] ? SW'(-nre2_q) : SW'(nre2_q);
  assign nim_abs = nim2_q[SW-1] ? SW'(-nim2_q) : SW'(nim2_q);
  assign nre_sh  = NW'(nre_abs) << FRAC_BITS;
  assign nim_sh  = NW'(nim_abs) << FRAC_BITS;
  assign den_top = CW'(den2_q) << W;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      func_o   <= f2_q;
      den_o    <= den2_q;
      dz_o     <= (f2_q == FUNC_DIV) && (den2_q == '0);
      re_neg_o <= 1'b0;
      im_neg_o <= 1'b0;
      re_mag_o <= '0;
      im_mag_o <= '0;
      big_re_o <= 1'b0;
      big_im_o <= 1'b0;
      rem_re_o <= '0;
      rem_im_o <= '0;
      priority if (f2_q == FUNC_DIV) begin
        re_neg_o <= nre2_q[SW-1];
        im_neg_o <= nim2_q[SW-1];
        big_re_o <= CW'(nre_sh) >= den_top;
        big_im_o <= CW'(nim_sh) >= den_top;
        rem_re_o <= nre_sh;
        rem_im_o <= nim_sh;
      end else if (f2_q == FUNC_MAG) begin
        rem_re_o <= NW'(mag2_q);
      end else begin
        re_neg_o <= sre2_q[SW-1];
        im_neg_o <= sim2_q[SW-1];
        re_mag_o <= (f2_q == FUNC_MUL) ? (sre_abs >> FRAC_BITS) : sre_abs;
        im_mag_o <= (f2_q == FUNC_MUL) ? (sim_abs >> FRAC_BITS) : sim_abs;
      end
    end
  end

endmodule

[src/cau_cell.sv]
module cau_cell import cau_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int IDX       = 0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [FUNC_BITS-1:0]           func_i,
  input  logic                           dz_i,
  input  logic                           re_neg_i,
  input  logic                           im_neg_i,
  input  logic [2*WORD_BITS:0]           re_mag_i,
  input  logic [2*WORD_BITS:0]           im_mag_i,
  input  logic                           big_re_i,
  input  logic                           big_im_i,
  input  logic [2*WORD_BITS-1:0]         den_i,
  input  logic [2*WORD_BITS+FRAC_BITS:0] rem_re_i,
  input  logic [2*WORD_BITS+FRAC_BITS:0] rem_im_i,
  output logic [FUNC_BITS-1:0]           func_o,
  output logic                           dz_o,
  output logic                           re_neg_o,
  output logic                           im_neg_o,
  output logic [2*WORD_BITS:0]           re_mag_o,
  output logic [2*WORD_BITS:0]           im_mag_o,
  output logic                           big_re_o,
  output logic                           big_im_o,
  output logic [2*WORD_BITS-1:0]         den_o,
  output logic [2*WORD_BITS+FRAC_BITS:0] rem_re_o,
  output logic [2*WORD_BITS+FRAC_BITS:0] rem_im_o
);

  localparam int W  = WORD_BITS;
  localparam int SW = 2 * W + 1;
  localparam int NW = 2 * W + FRAC_BITS + 1;
  localparam int CW = NW + W;
  localparam int K  = W - 1 - IDX;   // result bit settled here

  // one restoring step for each quotient, one step of the root
  logic [CW:0]   dre, dim;
  logic [SW-1:0] trial, sq_left;
  logic          sq_take;

  assign dre     = (CW+1)'(rem_re_i) - ((CW+1)'(den_i) << K);
  assign dim     = (CW+1)'(rem_im_i) - ((CW+1)'(den_i) << K);
  assign trial   = (SW'(re_mag_i[W-1:0]) << (K + 1)) | (SW'(1) << (2 * K));
  assign sq_take = rem_re_i[SW-1:0] >= trial;
  assign sq_left = rem_re_i[SW-1:0] - trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_o   <= func_i;
      dz_o     <= dz_i;
      re_neg_o <= re_neg_i;
      im_neg_o <= im_neg_i;
      big_re_o <= big_re_i;
      big_im_o <= big_im_i;
      den_o    <= den_i;
      re_mag_o <= re_mag_i;
      im_mag_o <= im_mag_i;
      rem_re_o <= rem_re_i;
      rem_im_o <= rem_im_i;
      unique case (func_i)
        FUNC_DIV: begin
          if (!dre[CW]) begin
            rem_re_o    <= dre[NW-1:0];
            re_mag_o[K] <= 1'b1;
          end
          if (!dim[CW]) begin
            rem_im_o    <= dim[NW-1:0];
            im_mag_o[K] <= 1'b1;
          end
        end
        FUNC_MAG: begin
          if (sq_take) begin
            rem_re_o    <= NW'(sq_left);
            re_mag_o[K] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[test/tb.sv]
module tb import cau_pkg::*;;

  localparam int WB = DEF_WORD_BITS;
  localparam int FB = DEF_FRAC_BITS;
  // the two opcodes the package leaves unused
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE7 = 3'd7;
  localparam logic [WB-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [WB-1:0] W_MIN = 32'h8000_0000;
  localparam logic [WB-1:0] W_ONE = 32'h0001_0000;
  localparam int  RANDOM_ITEMS = 1030;
  localparam int  DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
    logic          dz;
    logic          ovf;
  } cplx_res_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [WB-1:0]        ar, ai, br, bi;
    logic                 known;
    cplx_res_t            res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [4*WB-1:0]      s_axis_tdata = '0;   // a_re, a_im, b_re, b_im
  logic [FUNC_BITS-1:0] s_axis_tuser = '0;   // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*WB-1:0]      m_axis_tdata;        // res_re, res_im
  logic [1:0]           m_axis_tuser;        // div_by_zero, overflow

  cplx_res_t pending_results[$];
  int        mismatches = 0;
  longint    cycles = 0;

  complex_arithmetic_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // saturate an exact value to the word range
  function automatic logic [WB-1:0] clamp_word(input wide_t v, inout logic ovf);
    if (v > wide_t'(W_MAX)) begin
      ovf = 1'b1;
      return W_MAX;
    end
    if (v < -(wide_t'(1) <<< (WB - 1))) begin
      ovf = 1'b1;
      return W_MIN;
    end
    return v[WB-1:0];
  endfunction

  // integer square root, floor
  function automatic wide_t root_floor(input wide_t n);
    wide_t r, t;
    r = 0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // truncating shift toward zero
  function automatic wide_t drop_frac(input wide_t v);
    return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
  endfunction

  function automatic cplx_res_t predict_complex(input logic [FUNC_BITS-1:0] func,
      input logic [WB-1:0] ar_w, ai_w, br_w, bi_w);
    wide_t ar, ai, br, bi, re, im, den;
    cplx_res_t r;
    logic ovf;
    ar = wide_t'($signed(ar_w));
    ai = wide_t'($signed(ai_w));
    br = wide_t'($signed(br_w));
    bi = wide_t'($signed(bi_w));
    re = 0;
    im = 0;
    ovf = 1'b0;
    r = '0;
    case (func)
      FUNC_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      FUNC_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      FUNC_MUL: begin
        re = drop_frac(ar * br - ai * bi);
        im = drop_frac(ar * bi + ai * br);
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          return r;
        end
        re = ((ar * br + ai * bi) <<< FB) / den;
        im = ((ai * br - ar * bi) <<< FB) / den;
      end
      FUNC_MAG: re = root_floor(ar * ar + ai * ai);
      FUNC_R2C: re = ar;
      default: return r;
    endcase
    r.re  = clamp_word(re, ovf);
    r.im  = clamp_word(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [WB-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return ($urandom_range(0, 1)) ? W_MAX : W_MIN;
      4:       return ($urandom_range(0, 1)) ? '0 : '1;
      5:       return {$urandom} >> $urandom_range(0, 31);
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(input logic [FUNC_BITS-1:0] func,
      input logic [WB-1:0] ar, ai, br, bi, input logic known, input cplx_res_t res);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {bi, br, ai, ar};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(known ? res : predict_complex(func, ar, ai, br, bi));
  endtask

  task automatic idle_request(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // receiver: one long hold-off early on, then random stalls
  initial begin
    int n;
    @(posedge rst_ni);
    repeat (40) @(negedge clk_i) m_axis_tready <= 1'b1;
    repeat (300) @(negedge clk_i) m_axis_tready <= 1'b0;
    forever begin
      n = pick_gap();
      repeat (n) @(negedge clk_i) m_axis_tready <= 1'b0;
      n = $urandom_range(1, 30);
      repeat (n) @(negedge clk_i) m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cplx_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{re: m_axis_tdata[WB-1:0], im: m_axis_tdata[2*WB-1:WB],
              dz: m_axis_tuser[0], ovf: m_axis_tuser[1]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: re %h/%h im %h/%h dz %b/%b ovf %b/%b (exp/got)",
                     want.re, got.re, want.im, got.im, want.dz, got.dz,
                     want.ovf, got.ovf);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[complex_arithmetic_unit] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    logic [FUNC_BITS-1:0] f;
    logic [WB-1:0] ar, ai, br, bi;
    int drain;
    // directed rows; typed results only where obvious
    table_rows = '{
      '{FUNC_ADD, '0, '0, '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b0}},
      '{FUNC_ADD, W_MAX, W_MIN, W_MAX, W_MIN, 1'b1, '{W_MAX, W_MIN, 1'b0, 1'b1}},
      '{FUNC_ADD, W_MAX, W_MIN, W_MIN, W_MAX, 1'b1, '{'1, '1, 1'b0, 1'b0}},
      '{FUNC_SUB, W_MIN, W_MAX, W_ONE, '1, 1'b1, '{W_MIN, W_MAX, 1'b0, 1'b1}},
      '{FUNC_SUB, W_ONE, W_ONE, W_ONE, W_ONE, 1'b1, '{'0, '0, 1'b0, 1'b0}},
      '{FUNC_MUL, W_ONE, '0, W_ONE, '0, 1'b1, '{W_ONE, '0, 1'b0, 1'b0}},
      '{FUNC_MUL, W_MAX, W_MAX, W_MAX, W_MIN, 1'b0, '0},
      '{FUNC_MUL, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0, '0},
      '{FUNC_MUL, '1, 32'h1, 32'h3, '1, 1'b0, '0},
      '{FUNC_DIV, W_MAX, W_MIN, '0, '0, 1'b1, '{'0, '0, 1'b1, 1'b0}},
      '{FUNC_DIV, W_ONE, W_ONE, W_ONE, '0, 1'b1, '{W_ONE, W_ONE, 1'b0, 1'b0}},
      '{FUNC_DIV, W_MAX, W_MIN, 32'h1, '0, 1'b0, '0},
      '{FUNC_DIV, W_MIN, W_MAX, W_MIN, W_MIN, 1'b0, '0},
      '{FUNC_DIV, 32'h7, '1, '0, 32'h3, 1'b0, '0},
      '{FUNC_MAG, 32'h3_0000, 32'h4_0000, W_MAX, W_MIN, 1'b1, '{32'h5_0000, '0, 1'b0, 1'b0}},
      '{FUNC_MAG, W_MIN, W_MIN, '0, '0, 1'b1, '{W_MAX, '0, 1'b0, 1'b1}},
      '{FUNC_MAG, W_MAX, '1, '0, '0, 1'b0, '0},
      '{FUNC_R2C, W_MIN, W_MAX, W_MAX, W_MAX, 1'b1, '{W_MIN, '0, 1'b0, 1'b0}},
      '{FUNC_R2C, W_MAX, '0, '1, '1, 1'b1, '{W_MAX, '0, 1'b0, 1'b0}},
      '{FUNC_SPARE6, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1, '{'0, '0, 1'b0, 1'b0}},
      '{FUNC_SPARE7, '1, '1, '1, '1, 1'b1, '{'0, '0, 1'b0, 1'b0}}
    };
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (table_rows[i]) begin
      send_request(table_rows[i].func, table_rows[i].ar, table_rows[i].ai,
                   table_rows[i].br, table_rows[i].bi, table_rows[i].known,
                   table_rows[i].res);
      idle_request(pick_gap());
    end
    // random part; back-to-back early on so the receiver hold-off fills the pipe
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      f  = ($urandom_range(0, 39) == 0)
           ? FUNC_BITS'(FUNC_SPARE6 + $urandom_range(0, 1))
           : FUNC_BITS'($urandom_range(FUNC_ADD, FUNC_R2C));
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = pick_operand();
      if (f == FUNC_DIV && $urandom_range(0, 7) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(f, ar, ai, br, bi, 1'b0, '0);
      if (n > 120) idle_request(pick_gap());
    end
    idle_request(1);
    drain = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[complex_arithmetic_unit] OK");
    end else begin
      $display("[complex_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule
